### src/mtd_pkg.sv
// Shared types and constants of the multi-touch drag recogniser.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package mtd_pkg;

   localparam int POS_W    = 16;
   localparam int TRV_W    = 17;
   localparam int THR_W    = 33;
   localparam int ID_W     = 8;
   localparam int REQ_W    = 4;
   localparam int KIND_W   = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [1:0] OP_DOWN = 2'd0;
   localparam logic [1:0] OP_MOVE = 2'd1;
   localparam logic [1:0] OP_UP   = 2'd2;

   localparam logic [1:0] EV_STARTED = 2'd0;
   localparam logic [1:0] EV_MOVED   = 2'd1;
   localparam logic [1:0] EV_ENDED   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_REQ_PTRS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IN_KIND  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_THR_SQ   = 2'd2;

   typedef struct packed {
      logic [ID_W-1:0]         id;
      logic signed [POS_W-1:0] now_x;
      logic signed [POS_W-1:0] now_y;
      logic signed [POS_W-1:0] org_x;
      logic signed [POS_W-1:0] org_y;
      logic                    drag;
      logic                    eng;
   } cell_data_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic sq;
      logic upd;
      logic eng_set;
      logic eng_clr;
   } cell_cmd_type;

   typedef struct packed {
      logic [ID_W-1:0]         id;
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic [THR_W-1:0]        thr;
   } cell_bcast_type;

endpackage
`default_nettype wire

### src/multi_touch_drag_recognizer_top.sv
// Top level of the multi-touch drag recogniser: sequencer, pointer cell row,
// centroid dividers and result register. Depends on mtd_pkg, mtd_cell, mtd_div.
//
//  channel | ports  | direction | payload
//  request | req_*  | in        | op, pointer_id, pos_x, pos_y, input_kind, conflicts_clear
//  result  | rsp_*  | out       | event_res, centroid_x/y, travel_x/y, step_x/y
//  config  | csr_*  | in        | index, data (write only)
//
// A down or up item is decoded and returns to idle; an up that ends the gesture also
// emits its result. A move that reports passes the update, the walk over the cell row and
// the bit-serial centroid dividers, with a start step first when it starts or resumes the
// gesture. A move without a result returns to idle after the update or start step.
// Reset is synchronous and needs no clearing pass. A result waiting in the
// output register does not block the next item until that item has its own result.
`default_nettype none
module multi_touch_drag_recognizer_top #(
   parameter int MAX_POINTERS = 8
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire [1:0]                         req_op,
   input  wire [7:0]                         req_pointer_id,
   input  wire signed [15:0]                 req_pos_x,
   input  wire signed [15:0]                 req_pos_y,
   input  wire [1:0]                         req_input_kind,
   input  wire                               req_conflicts_clear,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [1:0]                        rsp_event_res,
   output logic signed [15:0]                rsp_centroid_x,
   output logic signed [15:0]                rsp_centroid_y,
   output logic signed [16:0]                rsp_travel_x,
   output logic signed [16:0]                rsp_travel_y,
   output logic signed [16:0]                rsp_step_x,
   output logic signed [16:0]                rsp_step_y,
   input  wire                               csr_we,
   input  wire [mtd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [mtd_pkg::THR_W-1:0]          csr_wdata
);
   import mtd_pkg::*;

   localparam int CNT_W = $clog2(MAX_POINTERS + 1);
   localparam int IDX_W = (MAX_POINTERS > 1) ? $clog2(MAX_POINTERS) : 1;
   localparam int CMP_W = CNT_W + REQ_W;
   localparam int SUM_W = POS_W + 1 + IDX_W;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_UPD, S_START, S_SUM, S_DIVGO, S_DIV, S_EMIT
   } state_type;

   typedef enum logic [1:0] {M_BEGIN, M_RESUME, M_MOVE, M_END} mode_type;

   function automatic logic signed [TRV_W-1:0] sat17(input logic signed [TRV_W:0] v);
      logic signed [TRV_W:0] lim;
      lim = (TRV_W+1)'(65535);
      if (v > lim) begin
         return TRV_W'(65535);
      end else if (v < -lim) begin
         return -TRV_W'(65535);
      end
      return v[TRV_W-1:0];
   endfunction

   function automatic logic signed [POS_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi, lo;
      hi = SUM_W'(32767);
      lo = -SUM_W'(32768);
      if (v > hi) begin
         return hi[POS_W-1:0];
      end else if (v < lo) begin
         return lo[POS_W-1:0];
      end
      return v[POS_W-1:0];
   endfunction

   state_type        state_ff;
   mode_type         mode_ff;
   logic [REQ_W-1:0] req_ptrs_ff;
   logic [KIND_W-1:0] in_kind_ff;
   logic [THR_W-1:0] thr_ff;
   logic [1:0]       op_ff;
   logic [KIND_W-1:0] kind_ff;
   logic             clear_ff;
   cell_bcast_type   bc_ff;
   logic [CNT_W-1:0] count_ff;
   logic             on_ff, paused_ff;
   logic signed [POS_W-1:0] last_x_ff, last_y_ff;
   logic signed [TRV_W-1:0] trv_x_ff, trv_y_ff, step_x_ff, step_y_ff;
   logic [IDX_W-1:0] sum_idx_ff;
   logic signed [SUM_W-1:0] acc_x_ff, acc_y_ff;
   logic             gate_ff;
   logic             rsp_valid_ff;
   logic [1:0]       rsp_ev_ff;
   logic signed [POS_W-1:0] rsp_cx_ff, rsp_cy_ff;
   logic signed [TRV_W-1:0] rsp_tx_ff, rsp_ty_ff, rsp_sx_ff, rsp_sy_ff;

   cell_cmd_type     cmd      [MAX_POINTERS];
   cell_data_type    cell_q   [MAX_POINTERS];
   cell_data_type    cell_nxt [MAX_POINTERS];
   logic [MAX_POINTERS-1:0] match, valid_mask, hit, eng_set, eng_bits;
   logic [IDX_W-1:0] first_idx;
   logic [REQ_W-1:0] need;
   logic [CMP_W-1:0] drags, engaged, run;
   logic             down_go, up_go, start_go, kind_ok, end_go;
   logic             div_busy_x, div_busy_y;
   logic signed [SUM_W-1:0] quo_x, quo_y;
   logic signed [POS_W-1:0] c_x, c_y;
   logic signed [TRV_W:0]   stp_x, stp_y, tsum_x, tsum_y;
   cell_data_type    rd;

   assign need      = (req_ptrs_ff == '0) ? REQ_W'(1) : req_ptrs_ff;
   assign kind_ok   = (kind_ff == in_kind_ff);
   assign hit       = match & valid_mask;
   assign req_ready = (state_ff == S_IDLE);
   assign down_go   = (state_ff == S_DECODE) && (op_ff == OP_DOWN) && kind_ok
                      && (count_ff < CNT_W'(MAX_POINTERS));
   assign up_go     = (state_ff == S_DECODE) && (op_ff == OP_UP) && kind_ok && (|hit);
   assign end_go    = up_go && (count_ff == CNT_W'(1)) && on_ff;
   assign start_go  = (state_ff == S_START) && (drags >= CMP_W'(need))
                      && (on_ff || clear_ff);
   assign rd        = cell_q[sum_idx_ff];
   assign c_x       = sat16(quo_x);
   assign c_y       = sat16(quo_y);
   assign stp_x     = (TRV_W+1)'(c_x) - (TRV_W+1)'(last_x_ff);
   assign stp_y     = (TRV_W+1)'(c_y) - (TRV_W+1)'(last_y_ff);
   assign tsum_x    = (TRV_W+1)'(trv_x_ff) + stp_x;
   assign tsum_y    = (TRV_W+1)'(trv_y_ff) + stp_y;

   always_comb begin
      first_idx = '0;
      drags     = '0;
      engaged   = '0;
      for (int i = MAX_POINTERS - 1; i >= 0; i--) begin
         valid_mask[i] = (CNT_W'(i) < count_ff);
         eng_bits[i]   = cell_q[i].eng;
         if (hit[i]) begin
            first_idx = IDX_W'(i);
         end
      end
      for (int i = 0; i < MAX_POINTERS; i++) begin
         drags   = drags + CMP_W'(valid_mask[i] & cell_q[i].drag);
         engaged = engaged + CMP_W'(valid_mask[i] & cell_q[i].eng);
      end
      run = engaged;
      for (int i = 0; i < MAX_POINTERS; i++) begin
         eng_set[i] = 1'b0;
         if (valid_mask[i] && cell_q[i].drag && !cell_q[i].eng && (run < CMP_W'(need))) begin
            eng_set[i] = 1'b1;
            run        = run + 1'b1;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_POINTERS; i++) begin
         cmd[i].load    = down_go && (count_ff == CNT_W'(i));
         cmd[i].shift   = up_go && (IDX_W'(i) >= first_idx);
         cmd[i].sq      = (state_ff == S_DECODE) && (op_ff == OP_MOVE);
         cmd[i].upd     = (state_ff == S_UPD) && hit[i];
         cmd[i].eng_set = start_go && eng_set[i];
         cmd[i].eng_clr = end_go;
         cell_nxt[i]    = (i == MAX_POINTERS - 1) ? cell_q[i] : cell_q[(i + 1) % MAX_POINTERS];
      end
   end

   for (genvar g = 0; g < MAX_POINTERS; g++) begin : g_cell
      mtd_cell u_cell (
         .clock (clock),
         .reset (reset),
         .cmd   (cmd[g]),
         .bcast (bc_ff),
         .nxt   (cell_nxt[g]),
         .data  (cell_q[g]),
         .match (match[g])
      );
   end

   mtd_div #(.W(SUM_W)) u_div_x (
      .clock (clock), .reset (reset), .start (state_ff == S_DIVGO),
      .dividend (acc_x_ff), .divisor (need), .busy (div_busy_x), .quotient (quo_x)
   );
   mtd_div #(.W(SUM_W)) u_div_y (
      .clock (clock), .reset (reset), .start (state_ff == S_DIVGO),
      .dividend (acc_y_ff), .divisor (need), .busy (div_busy_y), .quotient (quo_y)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= M_MOVE;
         req_ptrs_ff  <= REQ_W'(1);
         in_kind_ff   <= '0;
         thr_ff       <= THR_W'(400);
         count_ff     <= '0;
         on_ff        <= 1'b0;
         paused_ff    <= 1'b0;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         trv_x_ff     <= '0;
         trv_y_ff     <= '0;
         step_x_ff    <= '0;
         step_y_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_REQ_PTRS: req_ptrs_ff <= csr_wdata[REQ_W-1:0];
               REG_IN_KIND:  in_kind_ff  <= csr_wdata[KIND_W-1:0];
               REG_THR_SQ:   thr_ff      <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready && (state_ff != S_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff     <= req_op;
                  kind_ff   <= req_input_kind;
                  clear_ff  <= req_conflicts_clear;
                  bc_ff.id  <= req_pointer_id;
                  bc_ff.x   <= req_pos_x;
                  bc_ff.y   <= req_pos_y;
                  bc_ff.thr <= thr_ff;
                  state_ff  <= S_DECODE;
               end
            end
            S_DECODE: begin
               if (down_go) begin
                  count_ff <= count_ff + 1'b1;
               end
               if (up_go) begin
                  count_ff <= count_ff - 1'b1;
                  if (end_go) begin
                     on_ff     <= 1'b0;
                     paused_ff <= 1'b0;
                     step_x_ff <= '0;
                     step_y_ff <= '0;
                     mode_ff   <= M_END;
                  end else if (cell_q[first_idx].eng) begin
                     paused_ff <= 1'b1;
                  end
               end
               if (op_ff == OP_MOVE) begin
                  state_ff <= S_UPD;
               end else if (end_go) begin
                  state_ff <= S_EMIT;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_UPD: begin
               if ((|hit) && (!on_ff || paused_ff)) begin
                  state_ff <= S_START;
               end else if (|(hit & eng_bits)) begin
                  mode_ff  <= M_MOVE;
                  state_ff <= S_SUM;
               end else begin
                  state_ff <= S_IDLE;
               end
               sum_idx_ff <= '0;
               acc_x_ff   <= '0;
               acc_y_ff   <= '0;
            end
            S_START: begin
               if (start_go) begin
                  paused_ff <= 1'b0;
                  on_ff     <= 1'b1;
                  mode_ff   <= on_ff ? M_RESUME : M_BEGIN;
                  state_ff  <= S_SUM;
               end else begin
                  state_ff  <= S_IDLE;
               end
            end
            S_SUM: begin
               gate_ff <= (CMP_W'(count_ff) >= CMP_W'(need));
               if ((CMP_W'(count_ff) >= CMP_W'(need)) && valid_mask[sum_idx_ff] && rd.eng) begin
                  acc_x_ff <= acc_x_ff + SUM_W'(rd.now_x);
                  acc_y_ff <= acc_y_ff + SUM_W'(rd.now_y);
               end
               sum_idx_ff <= sum_idx_ff + 1'b1;
               if (sum_idx_ff == IDX_W'(MAX_POINTERS - 1)) begin
                  state_ff <= S_DIVGO;
               end
            end
            S_DIVGO: begin
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (!div_busy_x && !div_busy_y) begin
                  last_x_ff <= gate_ff ? c_x : '0;
                  last_y_ff <= gate_ff ? c_y : '0;
                  unique case (mode_ff)
                     M_BEGIN: begin
                        trv_x_ff  <= '0;
                        trv_y_ff  <= '0;
                        step_x_ff <= '0;
                        step_y_ff <= '0;
                     end
                     M_MOVE: begin
                        step_x_ff <= stp_x[TRV_W-1:0];
                        step_y_ff <= stp_y[TRV_W-1:0];
                        trv_x_ff  <= sat17(tsum_x);
                        trv_y_ff  <= sat17(tsum_y);
                     end
                     default: ;
                  endcase
                  state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ev_ff    <= (mode_ff == M_BEGIN) ? EV_STARTED :
                                  (mode_ff == M_END)   ? EV_ENDED : EV_MOVED;
                  rsp_cx_ff    <= last_x_ff;
                  rsp_cy_ff    <= last_y_ff;
                  rsp_tx_ff    <= trv_x_ff;
                  rsp_ty_ff    <= trv_y_ff;
                  rsp_sx_ff    <= step_x_ff;
                  rsp_sy_ff    <= step_y_ff;
                  if (mode_ff == M_END) begin
                     trv_x_ff  <= '0;
                     trv_y_ff  <= '0;
                     last_x_ff <= '0;
                     last_y_ff <= '0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_res  = rsp_ev_ff;
   assign rsp_centroid_x = rsp_cx_ff;
   assign rsp_centroid_y = rsp_cy_ff;
   assign rsp_travel_x   = rsp_tx_ff;
   assign rsp_travel_y   = rsp_ty_ff;
   assign rsp_step_x     = rsp_sx_ff;
   assign rsp_step_y     = rsp_sy_ff;

endmodule
`default_nettype wire

### src/mtd_cell.sv
// One pointer slot of the table: identity, positions, drag and engage flags.
// Depends on mtd_pkg; takes its neighbour's contents when the table closes a gap.
`default_nettype none
module mtd_cell (
   input  wire                      clock,
   input  wire                      reset,
   input  mtd_pkg::cell_cmd_type    cmd,
   input  mtd_pkg::cell_bcast_type  bcast,
   input  mtd_pkg::cell_data_type   nxt,
   output mtd_pkg::cell_data_type   data,
   output logic                     match
);
   import mtd_pkg::*;

   cell_data_type     data_ff;
   logic [31:0]       dx2_ff, dy2_ff;
   logic signed [16:0] dx, dy;
   logic signed [33:0] px2, py2;
   logic [THR_W-1:0]  d2;

   assign dx    = {bcast.x[POS_W-1], bcast.x} - {data_ff.org_x[POS_W-1], data_ff.org_x};
   assign dy    = {bcast.y[POS_W-1], bcast.y} - {data_ff.org_y[POS_W-1], data_ff.org_y};
   assign px2   = dx * dx;
   assign py2   = dy * dy;
   assign d2    = {1'b0, dx2_ff} + {1'b0, dy2_ff};
   assign data  = data_ff;
   assign match = (data_ff.id == bcast.id);

   always_ff @(posedge clock) begin
      if (cmd.sq) begin
         dx2_ff <= px2[31:0];
         dy2_ff <= py2[31:0];
      end
      if (cmd.load) begin
         data_ff.id    <= bcast.id;
         data_ff.now_x <= bcast.x;
         data_ff.now_y <= bcast.y;
         data_ff.org_x <= bcast.x;
         data_ff.org_y <= bcast.y;
      end else if (cmd.shift) begin
         data_ff.id    <= nxt.id;
         data_ff.now_x <= nxt.now_x;
         data_ff.now_y <= nxt.now_y;
         data_ff.org_x <= nxt.org_x;
         data_ff.org_y <= nxt.org_y;
      end else if (cmd.upd) begin
         data_ff.now_x <= bcast.x;
         data_ff.now_y <= bcast.y;
      end
      if (reset) begin
         data_ff.drag <= 1'b0;
         data_ff.eng  <= 1'b0;
      end else if (cmd.load) begin
         data_ff.drag <= 1'b0;
         data_ff.eng  <= 1'b0;
      end else if (cmd.shift) begin
         data_ff.drag <= nxt.drag;
         data_ff.eng  <= nxt.eng;
      end else begin
         if (cmd.upd && (d2 > bcast.thr)) begin
            data_ff.drag <= 1'b1;
         end
         if (cmd.eng_clr) begin
            data_ff.eng <= 1'b0;
         end else if (cmd.eng_set) begin
            data_ff.eng <= 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

### src/mtd_div.sv
// Restoring divider, one quotient bit a cycle, truncating toward zero.
// Depends on mtd_pkg for the divisor width.
`default_nettype none
module mtd_div #(
   parameter int W = 20
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             start,
   input  wire signed [W-1:0]              dividend,
   input  wire [mtd_pkg::REQ_W-1:0]        divisor,
   output logic                            busy,
   output logic signed [W-1:0]             quotient
);
   import mtd_pkg::*;

   localparam int CW = $clog2(W + 1);

   logic [W-1:0]     q_ff;
   logic [REQ_W-1:0] rem_ff;
   logic [REQ_W-1:0] d_ff;
   logic             neg_ff;
   logic             busy_ff;
   logic [CW-1:0]    cnt_ff;
   logic [REQ_W:0]   rem_sh;
   logic             take;

   assign rem_sh   = {rem_ff, q_ff[W-1]};
   assign take     = (rem_sh >= {1'b0, d_ff});
   assign busy     = busy_ff;
   assign quotient = neg_ff ? -$signed(q_ff) : $signed(q_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CW'(W);
         q_ff    <= dividend[W-1] ? W'(-dividend) : W'(dividend);
         neg_ff  <= dividend[W-1];
         rem_ff  <= '0;
         d_ff    <= divisor;
      end else if (busy_ff) begin
         rem_ff  <= take ? REQ_W'(rem_sh - {1'b0, d_ff}) : rem_sh[REQ_W-1:0];
         q_ff    <= {q_ff[W-2:0], take};
         cnt_ff  <= cnt_ff - 1'b1;
         busy_ff <= (cnt_ff != CW'(1));
      end
   end

endmodule
`default_nettype wire

### src/mtd_checker.sv
// Port-level checks of the drag recogniser, bound to the top level.
// Depends on mtd_pkg for the result codes.
`default_nettype none
module mtd_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [1:0]  rsp_event_res
);
   import mtd_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid && req_ready)
      else $error("Result channel not idle after reset.");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("A second item was taken while one is at work.");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_event_res == EV_STARTED || rsp_event_res == EV_MOVED
                     || rsp_event_res == EV_ENDED))
      else $error("Result carries an unknown event code.");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_event_res))
      else $error("Stalled result item changed.");

endmodule

bind multi_touch_drag_recognizer_top mtd_checker u_mtd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_event_res (rsp_event_res)
);
`default_nettype wire
